// ----- hdl/vgb_pkg.sv -----
// vgb_pkg: shared constants and types of the voxel grid with bounds block
`default_nettype none

package vgb_pkg;

   localparam int DEF_MAX_DIM      = 16;
   localparam int DEF_TEXTURE_BITS = 16;

   localparam int SIZE_W  = 5;
   localparam int COORD_W = 4;
   localparam int MODE_W  = 2;
   localparam int TEX_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TEXTURE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_TEX = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   typedef struct packed {
      logic occ_en;
      logic occ_set;
      logic tex_en;
   } wr_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [SIZE_W-1:0] x;
      logic [SIZE_W-1:0] y;
      logic [SIZE_W-1:0] z;
   } sample_type;

   typedef struct packed {
      logic              empty;
      logic [SIZE_W-1:0] min_x;
      logic [SIZE_W-1:0] max_x;
      logic [SIZE_W-1:0] min_y;
      logic [SIZE_W-1:0] max_y;
      logic [SIZE_W-1:0] min_z;
      logic [SIZE_W-1:0] max_z;
   } bounds_type;

endpackage

`default_nettype wire

// ----- hdl/vgb_grid_store.sv -----
// vgb_grid_store: occupancy and texture memories with the clearing pass after reset
`default_nettype none

module vgb_grid_store
   import vgb_pkg::*;
#(
   parameter int AW           = 12,
   parameter int TEXTURE_BITS = DEF_TEXTURE_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire wr_ctl_type              wr_ctl,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic [TEXTURE_BITS-1:0] wr_tex,
   input  wire logic [AW-1:0]           rd_addr,
   output logic                         rd_occ,
   output logic                         clear_busy
);

   localparam int DEPTH = 1 << AW;

   logic                    occ_mem [DEPTH];
   logic [TEXTURE_BITS-1:0] tex_mem [DEPTH];

   logic          clr_active_ff, clr_active_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          rd_occ_ff;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {AW{1'b1}}) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         occ_mem[clr_addr_ff] <= 1'b0;
      end else if (wr_ctl.occ_en) begin
         occ_mem[wr_addr] <= wr_ctl.occ_set;
      end
      rd_occ_ff <= occ_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         tex_mem[clr_addr_ff] <= '0;
      end else if (wr_ctl.tex_en) begin
         tex_mem[wr_addr] <= wr_tex;
      end
   end

   assign rd_occ     = rd_occ_ff;
   assign clear_busy = clr_active_ff;

endmodule

`default_nettype wire

// ----- hdl/vgb_scan_ctr.sv -----
// vgb_scan_ctr: walks every cell in use, one address per cycle
`default_nettype none

module vgb_scan_ctr
   import vgb_pkg::*;
#(
   parameter int CW = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SIZE_W-1:0] size_x,
   input  wire logic [SIZE_W-1:0] size_y,
   input  wire logic [SIZE_W-1:0] size_z,
   output logic [3*CW-1:0]        rd_addr,
   output sample_type             sample,
   output logic                   busy
);

   logic              active_ff, active_in;
   logic [SIZE_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   sample_type        sample_ff, sample_in;
   logic [CW+SIZE_W-1:0] x_ext, y_ext, z_ext;

   always_comb begin
      active_in = active_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (start) begin
         x_in = '0;
         y_in = '0;
         z_in = '0;
         active_in = (size_x != '0) && (size_y != '0) && (size_z != '0);
      end else if (active_ff) begin
         if (z_ff == size_z - 1'b1) begin
            z_in = '0;
            if (y_ff == size_y - 1'b1) begin
               y_in = '0;
               if (x_ff == size_x - 1'b1) begin
                  active_in = 1'b0;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end else begin
               y_in = y_ff + 1'b1;
            end
         end else begin
            z_in = z_ff + 1'b1;
         end
      end
      sample_in.valid = active_ff;
      sample_in.x     = x_ff;
      sample_in.y     = y_ff;
      sample_in.z     = z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         sample_ff.valid <= 1'b0;
      end else begin
         active_ff       <= active_in;
         sample_ff.valid <= sample_in.valid;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      sample_ff.x <= sample_in.x;
      sample_ff.y <= sample_in.y;
      sample_ff.z <= sample_in.z;
   end

   assign x_ext   = {{CW{1'b0}}, x_ff};
   assign y_ext   = {{CW{1'b0}}, y_ff};
   assign z_ext   = {{CW{1'b0}}, z_ff};
   assign rd_addr = {x_ext[CW-1:0], y_ext[CW-1:0], z_ext[CW-1:0]};
   assign sample  = sample_ff;
   assign busy    = active_ff || sample_ff.valid;

endmodule

`default_nettype wire

// ----- hdl/vgb_bound_unit.sv -----
// vgb_bound_unit: shared min and max compare unit that folds occupied cells into the box
`default_nettype none

module vgb_bound_unit
   import vgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              init,
   input  wire logic [SIZE_W-1:0] size_x,
   input  wire logic [SIZE_W-1:0] size_y,
   input  wire logic [SIZE_W-1:0] size_z,
   input  wire sample_type        sample,
   input  wire logic              occupied,
   output bounds_type             bounds
);

   logic              any_ff, any_in;
   logic [SIZE_W-1:0] lo_x_ff, lo_x_in, hi_x_ff, hi_x_in;
   logic [SIZE_W-1:0] lo_y_ff, lo_y_in, hi_y_ff, hi_y_in;
   logic [SIZE_W-1:0] lo_z_ff, lo_z_in, hi_z_ff, hi_z_in;
   logic [SIZE_W-1:0] nx, ny, nz;

   assign nx = sample.x + 1'b1;
   assign ny = sample.y + 1'b1;
   assign nz = sample.z + 1'b1;

   always_comb begin
      any_in  = any_ff;
      lo_x_in = lo_x_ff;
      hi_x_in = hi_x_ff;
      lo_y_in = lo_y_ff;
      hi_y_in = hi_y_ff;
      lo_z_in = lo_z_ff;
      hi_z_in = hi_z_ff;
      if (init) begin
         any_in  = 1'b0;
         lo_x_in = size_x;
         lo_y_in = size_y;
         lo_z_in = size_z;
         hi_x_in = '0;
         hi_y_in = '0;
         hi_z_in = '0;
      end else if (sample.valid && occupied) begin
         any_in = 1'b1;
         if (sample.x < lo_x_ff) lo_x_in = sample.x;
         if (sample.y < lo_y_ff) lo_y_in = sample.y;
         if (sample.z < lo_z_ff) lo_z_in = sample.z;
         if (nx > hi_x_ff) hi_x_in = nx;
         if (ny > hi_y_ff) hi_y_in = ny;
         if (nz > hi_z_ff) hi_z_in = nz;
      end
   end

   always_ff @(posedge clock) begin
      any_ff  <= any_in;
      lo_x_ff <= lo_x_in;
      hi_x_ff <= hi_x_in;
      lo_y_ff <= lo_y_in;
      hi_y_ff <= hi_y_in;
      lo_z_ff <= lo_z_in;
      hi_z_ff <= hi_z_in;
   end

   always_comb begin
      bounds.empty = !any_ff;
      bounds.min_x = any_ff ? lo_x_ff : '0;
      bounds.max_x = any_ff ? hi_x_ff : '0;
      bounds.min_y = any_ff ? lo_y_ff : '0;
      bounds.max_y = any_ff ? hi_y_ff : '0;
      bounds.min_z = any_ff ? lo_z_ff : '0;
      bounds.max_z = any_ff ? hi_z_ff : '0;
   end

endmodule

`default_nettype wire

// ----- hdl/voxel_grid_with_bounds.sv -----
// voxel_grid_with_bounds: top level of the voxel occupancy grid with bounding box
//
// Request beats (req_) add a voxel, remove a voxel or set a cell's texture. Each
// request gives exactly one response beat (rsp_) with the bounding box of the
// occupied cells in use, the empty flag, the out-of-range flag and the notify flag.
// A beat moves at a rising edge with valid high and stall low.
// The block works on one request at a time: req_stall is high from the accepting
// edge until the response is taken. The scan reads the occupancy memory one cell
// per cycle over the w*h*d cells in use (w, h, d the sizes clamped to MAX_DIM);
// it reads none when one of them is zero.
// A stalled response holds its values; the next request is taken the cycle after
// the response is accepted.
// csr_write writes register csr_index (0 width, 1 height, 2 depth, 3 default
// texture) from csr_data; the user must write only while no request is in flight,
// as the block itself does not enforce it.
// After reset a clearing pass walks both memories with req_stall high; CSR writes
// are taken meanwhile.
`default_nettype none

module voxel_grid_with_bounds
   import vgb_pkg::*;
#(
   parameter int MAX_DIM      = DEF_MAX_DIM,
   parameter int TEXTURE_BITS = DEF_TEXTURE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [COORD_W-1:0]    req_cell_x,
   input  wire logic [COORD_W-1:0]    req_cell_y,
   input  wire logic [COORD_W-1:0]    req_cell_z,
   input  wire logic [TEX_W-1:0]      req_texture_value,
   input  wire logic                  req_notify_request,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [SIZE_W-1:0]          rsp_min_x,
   output logic [SIZE_W-1:0]          rsp_max_x,
   output logic [SIZE_W-1:0]          rsp_min_y,
   output logic [SIZE_W-1:0]          rsp_max_y,
   output logic [SIZE_W-1:0]          rsp_min_z,
   output logic [SIZE_W-1:0]          rsp_max_z,
   output logic                       rsp_grid_empty,
   output logic                       rsp_out_of_range,
   output logic                       rsp_notify
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int AW = 3 * CW;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;

   logic [2:0] state_ff, state_in;

   logic [SIZE_W-1:0] width_ff, height_ff, depth_ff;
   logic [TEX_W-1:0]  def_tex_ff;
   logic              oor_ff, oor_in;
   logic              notify_ff, notify_in;

   logic [SIZE_W-1:0] eff_w, eff_h, eff_d;
   logic              accept, oor, known_mode;
   wr_ctl_type        wr_ctl;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CW+COORD_W-1:0]       cx_ext, cy_ext, cz_ext;
   logic [TEXTURE_BITS+TEX_W-1:0] tex_ext, def_ext;
   logic [TEXTURE_BITS-1:0]     wr_tex;
   logic              rd_occ, clear_busy, scan_busy;
   sample_type        sample;
   bounds_type        bounds;

   // size registers above MAX_DIM act as MAX_DIM
   assign eff_w = (32'(width_ff) > MAX_DIM)  ? SIZE_W'(MAX_DIM) : width_ff;
   assign eff_h = (32'(height_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : height_ff;
   assign eff_d = (32'(depth_ff) > MAX_DIM)  ? SIZE_W'(MAX_DIM) : depth_ff;

   assign accept     = req_valid && !req_stall;
   assign known_mode = (req_mode == MODE_ADD) || (req_mode == MODE_REMOVE) ||
                       (req_mode == MODE_TEXTURE);
   assign oor = ({1'b0, req_cell_x} >= eff_w) || ({1'b0, req_cell_y} >= eff_h) ||
                ({1'b0, req_cell_z} >= eff_d);

   assign cx_ext  = {{CW{1'b0}}, req_cell_x};
   assign cy_ext  = {{CW{1'b0}}, req_cell_y};
   assign cz_ext  = {{CW{1'b0}}, req_cell_z};
   assign wr_addr = {cx_ext[CW-1:0], cy_ext[CW-1:0], cz_ext[CW-1:0]};

   assign tex_ext = {{TEXTURE_BITS{1'b0}}, req_texture_value};
   assign def_ext = {{TEXTURE_BITS{1'b0}}, def_tex_ff};

   always_comb begin
      wr_ctl    = '0;
      wr_tex    = tex_ext[TEXTURE_BITS-1:0];
      oor_in    = oor_ff;
      notify_in = notify_ff;
      if (accept) begin
         oor_in    = known_mode && oor;
         notify_in = 1'b0;
         if (known_mode && !oor) begin
            unique case (req_mode)
               MODE_ADD: begin
                  wr_ctl.occ_en  = 1'b1;
                  wr_ctl.occ_set = 1'b1;
                  notify_in      = req_notify_request;
               end
               MODE_REMOVE: begin
                  wr_ctl.occ_en = 1'b1;
                  wr_ctl.tex_en = 1'b1;
                  wr_tex        = def_ext[TEXTURE_BITS-1:0];
                  notify_in     = 1'b1;
               end
               MODE_TEXTURE: begin
                  wr_ctl.tex_en = 1'b1;
               end
               default: begin
                  wr_ctl = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (!clear_busy) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_SCAN;
         ST_SCAN:  if (!scan_busy) state_in = ST_DONE;
         ST_DONE:  if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         width_ff   <= SIZE_RESET;
         height_ff  <= SIZE_RESET;
         depth_ff   <= SIZE_RESET;
         def_tex_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_WIDTH:   width_ff   <= csr_data[SIZE_W-1:0];
               CSR_HEIGHT:  height_ff  <= csr_data[SIZE_W-1:0];
               CSR_DEPTH:   depth_ff   <= csr_data[SIZE_W-1:0];
               CSR_DEF_TEX: def_tex_ff <= csr_data;
               default: ;
            endcase
         end
      end
      oor_ff    <= oor_in;
      notify_ff <= notify_in;
   end

   vgb_grid_store #(
      .AW           (AW),
      .TEXTURE_BITS (TEXTURE_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_ctl     (wr_ctl),
      .wr_addr    (wr_addr),
      .wr_tex     (wr_tex),
      .rd_addr    (rd_addr),
      .rd_occ     (rd_occ),
      .clear_busy (clear_busy)
   );

   vgb_scan_ctr #(
      .CW (CW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .size_x  (eff_w),
      .size_y  (eff_h),
      .size_z  (eff_d),
      .rd_addr (rd_addr),
      .sample  (sample),
      .busy    (scan_busy)
   );

   vgb_bound_unit u_bound (
      .clock    (clock),
      .init     (accept),
      .size_x   (eff_w),
      .size_y   (eff_h),
      .size_z   (eff_d),
      .sample   (sample),
      .occupied (rd_occ),
      .bounds   (bounds)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_min_x        = bounds.min_x;
   assign rsp_max_x        = bounds.max_x;
   assign rsp_min_y        = bounds.min_y;
   assign rsp_max_y        = bounds.max_y;
   assign rsp_min_z        = bounds.min_z;
   assign rsp_max_z        = bounds.max_z;
   assign rsp_grid_empty   = bounds.empty;
   assign rsp_out_of_range = oor_ff;
   assign rsp_notify       = notify_ff;

endmodule

`default_nettype wire

// ----- hdl/vgb_checker.sv -----
// vgb_checker: port-level assertions for the voxel grid with bounds, bound to the top level
`default_nettype none

module vgb_checker
   import vgb_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [SIZE_W-1:0] rsp_min_x,
   input wire logic [SIZE_W-1:0] rsp_max_x,
   input wire logic [SIZE_W-1:0] rsp_min_y,
   input wire logic [SIZE_W-1:0] rsp_max_y,
   input wire logic [SIZE_W-1:0] rsp_min_z,
   input wire logic [SIZE_W-1:0] rsp_max_z,
   input wire logic              rsp_grid_empty,
   input wire logic              rsp_out_of_range,
   input wire logic              rsp_notify
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_min_x) && $stable(rsp_max_x) &&
         $stable(rsp_grid_empty) && $stable(rsp_notify))
      else $error("response changed while stalled");

   // one request in flight: busy right after a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_empty |-> (rsp_min_x == '0) && (rsp_max_x == '0) &&
         (rsp_min_y == '0) && (rsp_max_y == '0) && (rsp_min_z == '0) && (rsp_max_z == '0))
      else $error("empty grid with nonzero bounds");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_grid_empty |-> (rsp_min_x < rsp_max_x) && (rsp_min_y < rsp_max_y) &&
         (rsp_min_z < rsp_max_z))
      else $error("bounding box out of order");

   a_oor_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> !rsp_notify)
      else $error("notify on out-of-range request");

endmodule

bind voxel_grid_with_bounds vgb_checker u_vgb_checker (.*);

`default_nettype wire

// ----- dv/voxel_grid_with_bounds_test.sv -----
// testbench: voxel grid with bounds, checked beat by beat against a bounding-box predictor
`timescale 1ns / 100ps

module voxel_grid_with_bounds_test;
   import vgb_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CELLS          = DEF_MAX_DIM * DEF_MAX_DIM * DEF_MAX_DIM;
   localparam int QUIET_LIMIT    = 50000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int TAIL_CYCLES    = 16;

   typedef struct {
      logic [SIZE_W-1:0] min_x, max_x, min_y, max_y, min_z, max_z;
      logic              empty, oor, notify;
   } box_beat_type;

   class bbox_board_type;
      bit               occupied [CELLS];
      logic [TEX_W-1:0] texture [CELLS];
      logic [SIZE_W-1:0] dim [3];
      logic [TEX_W-1:0] clear_texture;
      box_beat_type     pending_boxes [$];
      int               errors;
      int               checked;

      function new();
         foreach (occupied[i]) begin
            occupied[i] = 1'b0;
            texture[i]  = '0;
         end
         dim[0] = SIZE_RESET;
         dim[1] = SIZE_RESET;
         dim[2] = SIZE_RESET;
         clear_texture = '0;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WIDTH: begin
               dim[0] = value[SIZE_W-1:0];
            end
            CSR_HEIGHT: begin
               dim[1] = value[SIZE_W-1:0];
            end
            CSR_DEPTH: begin
               dim[2] = value[SIZE_W-1:0];
            end
            CSR_DEF_TEX: begin
               clear_texture = value[TEX_W-1:0];
            end
         endcase
      endfunction

      function int span(int axis);
         return (dim[axis] > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(dim[axis]);
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] x,
                                 logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                 logic [TEX_W-1:0] tex, logic notify_req);
         box_beat_type b;
         int w, h, d, cell_idx, i, j, k;
         int lo [3];
         int hi [3];
         w = span(0);
         h = span(1);
         d = span(2);
         b.oor    = 1'b0;
         b.notify = 1'b0;
         if (mode != MODE_UNUSED) begin
            b.oor = (int'(x) >= w) || (int'(y) >= h) || (int'(z) >= d);
            if (!b.oor) begin
               cell_idx = (int'(x) * DEF_MAX_DIM + int'(y)) * DEF_MAX_DIM + int'(z);
               case (mode)
                  MODE_ADD: begin
                     occupied[cell_idx] = 1'b1;
                     b.notify = notify_req;
                  end
                  MODE_REMOVE: begin
                     occupied[cell_idx] = 1'b0;
                     texture[cell_idx]  = clear_texture;
                     b.notify = 1'b1;
                  end
                  default: begin
                     texture[cell_idx] = tex;
                  end
               endcase
            end
         end
         lo[0] = w;
         lo[1] = h;
         lo[2] = d;
         hi[0] = 0;
         hi[1] = 0;
         hi[2] = 0;
         b.empty = 1'b1;
         for (i = 0; i < w; i++)
            for (j = 0; j < h; j++)
               for (k = 0; k < d; k++) begin
                  if (occupied[(i * DEF_MAX_DIM + j) * DEF_MAX_DIM + k]) begin
                     b.empty = 1'b0;
                     if (i < lo[0]) lo[0] = i;
                     if (i + 1 > hi[0]) hi[0] = i + 1;
                     if (j < lo[1]) lo[1] = j;
                     if (j + 1 > hi[1]) hi[1] = j + 1;
                     if (k < lo[2]) lo[2] = k;
                     if (k + 1 > hi[2]) hi[2] = k + 1;
                  end
               end
         if (b.empty) begin
            lo = '{0, 0, 0};
            hi = '{0, 0, 0};
         end
         b.min_x = SIZE_W'(lo[0]);
         b.max_x = SIZE_W'(hi[0]);
         b.min_y = SIZE_W'(lo[1]);
         b.max_y = SIZE_W'(hi[1]);
         b.min_z = SIZE_W'(lo[2]);
         b.max_z = SIZE_W'(hi[2]);
         pending_boxes.insert(pending_boxes.size(), b);
      endfunction

      function void field_check(string name, int want, int seen);
         if (want != seen) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_box(box_beat_type got);
         box_beat_type want;
         if (pending_boxes.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            errors++;
         end else begin
            want = pending_boxes.pop_front();
            checked++;
            field_check("min_x", int'(want.min_x), int'(got.min_x));
            field_check("max_x", int'(want.max_x), int'(got.max_x));
            field_check("min_y", int'(want.min_y), int'(got.min_y));
            field_check("max_y", int'(want.max_y), int'(got.max_y));
            field_check("min_z", int'(want.min_z), int'(got.min_z));
            field_check("max_z", int'(want.max_z), int'(got.max_z));
            field_check("grid_empty", int'(want.empty), int'(got.empty));
            field_check("out_of_range", int'(want.oor), int'(got.oor));
            field_check("notify", int'(want.notify), int'(got.notify));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode = '0;
   logic [COORD_W-1:0]    req_cell_x = '0;
   logic [COORD_W-1:0]    req_cell_y = '0;
   logic [COORD_W-1:0]    req_cell_z = '0;
   logic [TEX_W-1:0]      req_texture_value = '0;
   logic                  req_notify_request = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SIZE_W-1:0]     rsp_min_x, rsp_max_x, rsp_min_y, rsp_max_y, rsp_min_z, rsp_max_z;
   logic                  rsp_grid_empty, rsp_out_of_range, rsp_notify;

   bbox_board_type board = new();
   box_beat_type rsp_seen;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int holdoff_asks = 0;
   int holdoff_done = 0;
   int holdoff_left = 0;
   int quiet_cycles = 0;
   int settings = 0;

   voxel_grid_with_bounds u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_cell_x         (req_cell_x),
      .req_cell_y         (req_cell_y),
      .req_cell_z         (req_cell_z),
      .req_texture_value  (req_texture_value),
      .req_notify_request (req_notify_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_min_x          (rsp_min_x),
      .rsp_max_x          (rsp_max_x),
      .rsp_min_y          (rsp_min_y),
      .rsp_max_y          (rsp_max_y),
      .rsp_min_z          (rsp_min_z),
      .rsp_max_z          (rsp_max_z),
      .rsp_grid_empty     (rsp_grid_empty),
      .rsp_out_of_range   (rsp_out_of_range),
      .rsp_notify         (rsp_notify)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response beat checked before a request beat noted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen.min_x  = rsp_min_x;
            rsp_seen.max_x  = rsp_max_x;
            rsp_seen.min_y  = rsp_min_y;
            rsp_seen.max_y  = rsp_max_y;
            rsp_seen.min_z  = rsp_min_z;
            rsp_seen.max_z  = rsp_max_z;
            rsp_seen.empty  = rsp_grid_empty;
            rsp_seen.oor    = rsp_out_of_range;
            rsp_seen.notify = rsp_notify;
            board.check_box(rsp_seen);
         end
         if (req_valid && !req_stall)
            board.note_request(req_mode, req_cell_x, req_cell_y, req_cell_z,
                               req_texture_value, req_notify_request);
      end
   end

   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else if (holdoff_asks != holdoff_done) begin
         holdoff_done = holdoff_done + 1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                               input logic [TEX_W-1:0] tex, input logic notify_req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_cell_x         <= x;
      req_cell_y         <= y;
      req_cell_z         <= z;
      req_texture_value  <= tex;
      req_notify_request <= notify_req;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_boxes.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      board.set_register(idx, value);
   endtask

   task automatic set_grid(input logic [CSR_DATA_W-1:0] wd, input logic [CSR_DATA_W-1:0] hd,
                           input logic [CSR_DATA_W-1:0] dd, input logic [CSR_DATA_W-1:0] tex);
      write_reg(CSR_WIDTH, wd);
      write_reg(CSR_HEIGHT, hd);
      write_reg(CSR_DEPTH, dd);
      write_reg(CSR_DEF_TEX, tex);
      csr_write <= 1'b0;
      settings++;
   endtask

   function automatic logic [TEX_W-1:0] rand_tex();
      return TEX_W'($urandom_range(16'hFFFF));
   endfunction

   // size register word with junk in the unused upper bits
   function automatic logic [CSR_DATA_W-1:0] size_word(int s);
      logic [CSR_DATA_W-SIZE_W-1:0] junk;
      junk = (CSR_DATA_W-SIZE_W)'($urandom_range(2 ** (CSR_DATA_W - SIZE_W) - 1));
      return {junk, s[SIZE_W-1:0]};
   endfunction

   // mostly inside the sizes in use, now and then anywhere
   function automatic logic [COORD_W-1:0] pick_coord(int s);
      int lim;
      lim = (s > DEF_MAX_DIM) ? DEF_MAX_DIM : s;
      if ($urandom_range(9) == 0 || lim == 0)
         return COORD_W'($urandom_range(DEF_MAX_DIM - 1));
      return COORD_W'($urandom_range(lim - 1));
   endfunction

   initial begin
      int phase, i, n, w, h, d, r;
      logic [MODE_W-1:0] m;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // full grid at reset sizes: corners, texture, unused mode, remove of empty cell
      send_idle_pct = 12;
      rsp_idle_pct  = 45;
      send_request(MODE_ADD, 4'd0, 4'd0, 4'd0, rand_tex(), 1'b0);
      send_request(MODE_ADD, 4'd15, 4'd15, 4'd15, rand_tex(), 1'b1);
      send_request(MODE_TEXTURE, 4'd15, 4'd15, 4'd15, 16'hFFFF, 1'b1);
      send_request(MODE_REMOVE, 4'd0, 4'd0, 4'd0, 16'h0000, 1'b0);
      send_request(MODE_UNUSED, 4'd3, 4'd4, 4'd5, rand_tex(), 1'b1);
      send_request(MODE_REMOVE, 4'd15, 4'd15, 4'd15, rand_tex(), 1'b1);
      send_request(MODE_REMOVE, 4'd7, 4'd7, 4'd7, rand_tex(), 1'b0);
      send_request(MODE_TEXTURE, 4'd0, 4'd15, 4'd0, 16'h0000, 1'b0);
      drain();

      // single cell grid, out-of-range on each axis
      set_grid(16'd1, 16'd1, 16'd1, 16'hFFFF);
      send_request(MODE_ADD, 4'd0, 4'd0, 4'd0, rand_tex(), 1'b1);
      send_request(MODE_ADD, 4'd1, 4'd0, 4'd0, rand_tex(), 1'b1);
      send_request(MODE_REMOVE, 4'd0, 4'd15, 4'd0, rand_tex(), 1'b1);
      send_request(MODE_TEXTURE, 4'd0, 4'd0, 4'd15, rand_tex(), 1'b0);
      send_request(MODE_UNUSED, 4'd15, 4'd15, 4'd15, rand_tex(), 1'b0);
      send_request(MODE_REMOVE, 4'd0, 4'd0, 4'd0, rand_tex(), 1'b0);
      drain();

      // zero width: every known-mode request out of range, nothing scanned
      set_grid(16'd0, 16'd16, 16'd16, 16'h0000);
      send_request(MODE_ADD, 4'd0, 4'd0, 4'd0, rand_tex(), 1'b1);
      send_request(MODE_UNUSED, 4'd0, 4'd0, 4'd0, rand_tex(), 1'b1);
      drain();

      // width above the maximum clamps, cells left outside the sizes keep their state
      set_grid(16'hFFFF, 16'd3, 16'd2, 16'h0000);
      send_request(MODE_ADD, 4'd15, 4'd2, 4'd1, rand_tex(), 1'b1);
      send_request(MODE_ADD, 4'd0, 4'd0, 4'd0, rand_tex(), 1'b0);
      send_request(MODE_ADD, 4'd15, 4'd3, 4'd1, rand_tex(), 1'b1);
      send_request(MODE_ADD, 4'd4, 4'd1, 4'd2, rand_tex(), 1'b1);
      drain();

      for (phase = 0; phase < 7; phase++) begin
         send_idle_pct = (phase < 2) ? 12 : (phase < 4) ? 45 : 0;
         rsp_idle_pct  = (phase < 2) ? 45 : (phase < 4) ? 12 : 0;
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 6);
         d = $urandom_range(1, 6);
         if (phase == 1)
            w = $urandom_range(17, 31);
         if (phase == 4) begin
            w = 16;
            h = 16;
            d = 16;
         end
         n = (phase == 4) ? 12 : 18;
         set_grid(size_word(w), size_word(h), size_word(d), rand_tex());
         for (i = 0; i < n; i++) begin
            if (phase == 5 && i == 3)
               holdoff_asks++;
            r = $urandom_range(99);
            m = (r < 45) ? MODE_ADD : (r < 70) ? MODE_REMOVE :
                (r < 90) ? MODE_TEXTURE : MODE_UNUSED;
            send_request(m, pick_coord(w), pick_coord(h), pick_coord(d),
                         rand_tex(), 1'($urandom_range(1)));
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.pending_boxes.size() != 0)
         $display("%0t: %0d response beats never arrived", $time, board.pending_boxes.size());
      $display("checked %0d response beats over %0d grid size settings", board.checked, settings);
      $display("including single cell, zero, clamped and full grids with out-of-range beats");
      if (board.errors == 0 && board.pending_boxes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/vgb_pkg.sv
hdl/vgb_grid_store.sv
hdl/vgb_scan_ctr.sv
hdl/vgb_bound_unit.sv
hdl/voxel_grid_with_bounds.sv
hdl/vgb_checker.sv
dv/voxel_grid_with_bounds_test.sv
